@@ hw/rtl/ale_pkg.sv @@
package ale_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    localparam logic [2:0] FN_APPEND  = 3'd0;
    localparam logic [2:0] FN_INSERT  = 3'd1;
    localparam logic [2:0] FN_DELETE  = 3'd2;
    localparam logic [2:0] FN_REVERSE = 3'd3;
    localparam logic [2:0] FN_MINMAX  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] INS_MAX_POS = ADDR_W'(DEPTH - 2);

    typedef struct packed {
        logic [2:0]               func;
        logic [ADDR_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] min_value;
        logic [ADDR_W-1:0]        min_index;
        logic signed [DATA_W-1:0] max_value;
        logic [ADDR_W-1:0]        max_index;
        logic [CNT_W-1:0]         count;
        logic [1:0]               status;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_INS_VAL,
        S_DEL_HEAD,
        S_DEL,
        S_REV_A,
        S_REV_B,
        S_REV_C,
        S_REV_D,
        S_MM,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/ale_ram.sv @@
module ale_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hw/rtl/array_list_engine_unit.sv @@
// Channel   Handshake              Payload    Transfer
// command   start / busy           i_item     edge with start high and busy low
// result    o_done (one cycle)     o_result   edge that ends the o_done cycle
//
// Append, insert at or past the tail, reverse of under two entries and every error
// case go straight to the done state. Insert shifts the tail up from the position
// and writes the value; delete shifts later entries down; reverse swaps end pairs;
// min/max scans the list. The list lives in one single-port-read memory.
// Synchronous active-low reset empties the list; the receiver cannot stall.
module array_list_engine_unit
    import ale_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_hi, n_hi;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic              r_wv, n_wv;
    logic [ADDR_W-1:0] r_wa, n_wa;
    logic              r_rv, n_rv;
    logic [ADDR_W-1:0] r_ri, n_ri;
    logic signed [DATA_W-1:0] r_tmp, n_tmp;
    logic signed [DATA_W-1:0] r_removed, n_removed;
    logic signed [DATA_W-1:0] r_mn, n_mn;
    logic signed [DATA_W-1:0] r_mx, n_mx;
    logic [ADDR_W-1:0] r_mni, n_mni;
    logic [ADDR_W-1:0] r_mxi, n_mxi;
    logic [1:0]        r_status, n_status;
    logic              r_done;
    t_result           r_res;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic signed [DATA_W-1:0] rdata;
    logic              fin;

    logic              accept;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  pos_ext;

    assign accept  = start && (r_state == S_IDLE);
    assign full    = (r_cnt == DEPTH_CNT);
    assign empty   = (r_cnt == '0);
    assign pos_ext = {1'b0, i_item.position};
    assign busy    = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    ale_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DONE;
                    case (i_item.func)
                        FN_INSERT: begin
                            if (!full && i_item.position <= INS_MAX_POS && pos_ext < r_cnt) begin
                                n_state = S_INS;
                            end
                        end
                        FN_DELETE: begin
                            if (!empty && pos_ext < r_cnt) begin
                                n_state = S_DEL_HEAD;
                            end
                        end
                        FN_REVERSE: begin
                            if (r_cnt >= CNT_W'(2)) begin
                                n_state = S_REV_A;
                            end
                        end
                        FN_MINMAX: begin
                            if (!empty) begin
                                n_state = S_MM;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS: begin
                if (r_ptr[ADDR_W-1:0] == r_pos) begin
                    n_state = S_INS_LAST;
                end
            end
            S_INS_LAST: n_state = S_INS_VAL;
            S_INS_VAL:  n_state = S_DONE;
            S_DEL_HEAD: n_state = S_DEL;
            S_DEL: begin
                if (r_ptr == r_cnt) begin
                    n_state = S_DONE;
                end
            end
            S_REV_A: n_state = S_REV_B;
            S_REV_B: n_state = S_REV_C;
            S_REV_C: n_state = S_REV_D;
            S_REV_D: begin
                if (r_ptr + CNT_W'(2) < {1'b0, r_hi}) begin
                    n_state = S_REV_A;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MM: begin
                if (r_ptr == r_cnt) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_hi      = r_hi;
        n_pos     = r_pos;
        n_val     = r_val;
        n_wv      = r_wv;
        n_wa      = r_wa;
        n_rv      = r_rv;
        n_ri      = r_ri;
        n_tmp     = r_tmp;
        n_removed = r_removed;
        n_mn      = r_mn;
        n_mx      = r_mx;
        n_mni     = r_mni;
        n_mxi     = r_mxi;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_wa;
        mem_wdata = rdata;
        mem_raddr = r_ptr[ADDR_W-1:0];
        fin       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_removed = '0;
                    n_mn      = '0;
                    n_mx      = '0;
                    n_mni     = '0;
                    n_mxi     = '0;
                    n_status  = ST_OK;
                    n_pos     = i_item.position;
                    n_val     = i_item.value;
                    n_wv      = 1'b0;
                    n_rv      = 1'b0;
                    case (i_item.func)
                        FN_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_cnt[ADDR_W-1:0];
                                mem_wdata = i_item.value;
                                n_cnt     = r_cnt + 1'b1;
                            end
                        end
                        FN_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (i_item.position > INS_MAX_POS) begin
                                n_status = ST_BADPOS;
                            end else if (pos_ext < r_cnt) begin
                                n_ptr = r_cnt - 1'b1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_cnt[ADDR_W-1:0];
                                mem_wdata = i_item.value;
                                n_cnt     = r_cnt + 1'b1;
                            end
                        end
                        FN_DELETE: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (pos_ext >= r_cnt) begin
                                n_status = ST_BADPOS;
                            end else begin
                                mem_raddr = i_item.position;
                                n_ptr     = pos_ext + 1'b1;
                            end
                        end
                        FN_REVERSE: begin
                            n_ptr = '0;
                            n_hi  = ADDR_W'(r_cnt - 1'b1);
                        end
                        FN_MINMAX: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_raddr = '0;
                                n_rv      = 1'b1;
                                n_ri      = '0;
                                n_ptr     = CNT_W'(1);
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_INS: begin
                mem_we    = r_wv;
                mem_raddr = r_ptr[ADDR_W-1:0];
                n_wv      = 1'b1;
                n_wa      = ADDR_W'(r_ptr + 1'b1);
                n_ptr     = r_ptr - 1'b1;
            end
            S_INS_LAST: begin
                mem_we = 1'b1;
                n_wv   = 1'b0;
            end
            S_INS_VAL: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_val;
                n_cnt     = r_cnt + 1'b1;
            end
            S_DEL_HEAD: begin
                n_removed = rdata;
                n_wv      = 1'b0;
            end
            S_DEL: begin
                mem_we = r_wv;
                if (r_ptr == r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    n_wv  = 1'b0;
                end else begin
                    mem_raddr = r_ptr[ADDR_W-1:0];
                    n_wv      = 1'b1;
                    n_wa      = ADDR_W'(r_ptr - 1'b1);
                    n_ptr     = r_ptr + 1'b1;
                end
            end
            S_REV_A: begin
                mem_raddr = r_ptr[ADDR_W-1:0];
            end
            S_REV_B: begin
                mem_raddr = r_hi;
                n_tmp     = rdata;
            end
            S_REV_C: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[ADDR_W-1:0];
                mem_wdata = rdata;
            end
            S_REV_D: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = r_tmp;
                n_ptr     = r_ptr + 1'b1;
                n_hi      = r_hi - 1'b1;
            end
            S_MM: begin
                if (r_rv) begin
                    if (r_ri == '0) begin
                        n_mn  = rdata;
                        n_mx  = rdata;
                        n_mni = '0;
                        n_mxi = '0;
                    end else if (rdata < r_mn) begin
                        n_mn  = rdata;
                        n_mni = r_ri;
                    end else if (r_mx < rdata) begin
                        n_mx  = rdata;
                        n_mxi = r_ri;
                    end
                end
                if (r_ptr != r_cnt) begin
                    mem_raddr = r_ptr[ADDR_W-1:0];
                    n_rv      = 1'b1;
                    n_ri      = r_ptr[ADDR_W-1:0];
                    n_ptr     = r_ptr + 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
            end
            S_DONE: begin
                fin = 1'b1;
            end
            default: fin = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wv    <= 1'b0;
            r_rv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wv    <= n_wv;
            r_rv    <= n_rv;
            r_done  <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_hi      <= n_hi;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_wa      <= n_wa;
        r_ri      <= n_ri;
        r_tmp     <= n_tmp;
        r_removed <= n_removed;
        r_mn      <= n_mn;
        r_mx      <= n_mx;
        r_mni     <= n_mni;
        r_mxi     <= n_mxi;
        r_status  <= n_status;
        if (fin) begin
            r_res.removed_value <= r_removed;
            r_res.min_value     <= r_mn;
            r_res.min_index     <= r_mni;
            r_res.max_value     <= r_mx;
            r_res.max_index     <= r_mxi;
            r_res.count         <= r_cnt;
            r_res.status        <= r_status;
        end
    end

endmodule
